// ----- rtl/core/lens_distortion_reproject_error_core_macros.svh -----
// Assertion helpers for the lens distortion reprojection core.
`ifndef LENS_DISTORTION_REPROJECT_ERROR_CORE_MACROS_SVH
`define LENS_DISTORTION_REPROJECT_ERROR_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define LDRE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define LDRE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define LDRE_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define LDRE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/core/ldre_pkg.sv -----
package ldre_pkg;

    localparam int COORD_W     = 28;
    localparam int NORM_FRAC   = 30;
    localparam int COEF_FRAC   = 29;
    localparam int SQRT_STEPS  = 32;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 32;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic signed [63:0] norm_t;

    localparam norm_t SAT_HI   = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam norm_t SAT_LO   = 64'shC000_0000_0000_0000;
    localparam norm_t NORM_ONE = 64'sh0000_0000_4000_0000;

    localparam logic [CFG_INDEX_W-1:0] REG_FOCAL_X       = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FOCAL_Y       = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_X      = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_Y      = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_RADIAL_K1     = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_RADIAL_K2     = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_TANGENTIAL_P1 = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_TANGENTIAL_P2 = 4'd7;

    typedef struct packed {
        coord_t observed_u;
        coord_t observed_v;
        coord_t estimate_u;
        coord_t estimate_v;
    } item_t;

    typedef struct packed {
        logic signed [31:0] distorted_u;
        logic signed [31:0] distorted_v;
        logic [31:0]        error_distance;
    } result_t;

    // Normalized values live in [-2^62, 2^62 - 1]; the top three bits of a
    // 65-bit sum agree exactly when it is in that range.
    function automatic norm_t sat_add(input norm_t a, input norm_t b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if ((s[64:62] == 3'b000) || (s[64:62] == 3'b111))
        begin
            return s[63:0];
        end
        return s[64] ? SAT_LO : SAT_HI;
    endfunction

endpackage

// ----- rtl/core/lens_distortion_reproject_error_core.sv -----
// Lens distortion reprojection error core.
// The item channel takes an observed pixel and an estimated undistorted
// pixel; the result channel returns the estimate pushed through the radial
// and tangential lens model, and its distance to the observed pixel.
// Both channels use valid/ready; one word is moved when both are high.
// Registers are written through cfg_we, cfg_index and cfg_data; the user
// must write them only while no word is in flight, which the block itself
// does not enforce. Indexes beyond the list are ignored. From acceptance to
// result_valid a word passes a 58-step restoring divider for normalization,
// a chain of five pipelined 64-bit multiplies, and a 32-step square root.
// Throughput is one word per cycle while the receiver takes results.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and item_ready drops; nothing is lost or repeated.
// Reset clears all valid bits and loads focal lengths of 1.0 pixel with
// zero center and coefficients.
`include "lens_distortion_reproject_error_core_macros.svh"

module lens_distortion_reproject_error_core #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  ldre_pkg::item_t                     item,
    output logic                                result_valid,
    input  logic                                result_ready,
    output ldre_pkg::result_t                   result,
    input  logic                                cfg_we,
    input  logic [ldre_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ldre_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int MAG_W     = ldre_pkg::COORD_W;
    localparam int DIV_STEPS = MAG_W + ldre_pkg::NORM_FRAC;
    localparam int MUL_LAT   = 4;
    localparam int T_X       = DIV_STEPS + 1;
    localparam int T_M1      = T_X + MUL_LAT;
    localparam int T_R       = T_M1 + 1;
    localparam int T_S       = T_R + 1;
    localparam int T_M2      = T_R + MUL_LAT;
    localparam int T_RA      = T_M2 + 1;
    localparam int T_M3      = T_M2 + MUL_LAT;
    localparam int T_RAD     = T_M3 + 1;
    localparam int T_M4      = T_RAD + MUL_LAT;
    localparam int T_TG      = T_S + MUL_LAT;
    localparam int T_XA      = T_M4 + 1;
    localparam int T_XD      = T_XA + 1;
    localparam int T_M5      = T_XD + MUL_LAT;
    localparam int T_PU      = T_M5 + 1;
    localparam int T_DU      = T_PU + 1;
    localparam int T_SQ      = T_DU + 1;
    localparam int T_SUM     = T_SQ + 1;
    localparam int T_LAST    = T_SUM + ldre_pkg::SQRT_STEPS;
    localparam int D_RA      = T_M3 - T_RA + 1;
    localparam int D_X       = T_RAD - T_X;
    localparam int D_T       = T_M4 - T_TG;
    localparam int D_POS     = T_LAST - T_DU + 1;
    localparam int NSQ       = ldre_pkg::SQRT_STEPS;

    localparam logic [MAG_W-1:0] FOCAL_ONE = MAG_W'(1) << COORD_FRAC_BITS;

    // Configuration registers
    logic [MAG_W-1:0]   focal_x_reg, focal_y_reg, center_x_reg, center_y_reg;
    logic signed [31:0] radial_k1_reg, radial_k2_reg, tangential_p1_reg, tangential_p2_reg;

    logic [MAG_W-1:0]   foc_eff [2];
    logic [MAG_W-1:0]   ctr [2];
    ldre_pkg::norm_t    k1_ext, k2_ext, p1_ext, p2_ext;
    ldre_pkg::norm_t    tg_coef_a [2];
    ldre_pkg::norm_t    tg_coef_c [2];

    logic               pipe_ce;
    logic [T_LAST:0]    v_reg;

    // Input stage and divider
    logic [MAG_W:0]     in_diff [2];
    logic [MAG_W-1:0]   in_est [2];
    logic [MAG_W-1:0]   obs_reg [2][T_PU+1];
    logic [MAG_W-1:0]   dv_rem_reg [2][DIV_STEPS+1];
    logic [MAG_W-1:0]   dv_mag_reg [2][DIV_STEPS+1];
    logic [DIV_STEPS-1:0] dv_quo_reg [2][DIV_STEPS+1];
    logic               dv_neg_reg [2][DIV_STEPS+1];
    logic [MAG_W:0]     dv_trial [2][DIV_STEPS+1];
    logic               dv_fit [2][DIV_STEPS+1];
    logic [63:0]        q_ext [2];

    // Lens model
    ldre_pkg::norm_t    x_reg [2];
    ldre_pkg::norm_t    xx, yy, xy;
    ldre_pkg::norm_t    r2_reg, xy_reg, xy_s_reg;
    ldre_pkg::norm_t    sq2_reg [2];
    ldre_pkg::norm_t    ts_reg [2];
    ldre_pkg::norm_t    r4, t1, t2;
    ldre_pkg::norm_t    rad_a_reg [D_RA];
    ldre_pkg::norm_t    radial_reg;
    ldre_pkg::norm_t    xdl_reg [2][D_X];
    ldre_pkg::norm_t    xr [2];
    ldre_pkg::norm_t    ta [2];
    ldre_pkg::norm_t    tc [2];
    ldre_pkg::norm_t    ta_reg [2][D_T];
    ldre_pkg::norm_t    tc_reg [2][D_T];
    ldre_pkg::norm_t    xa_reg [2];
    ldre_pkg::norm_t    xc_reg [2];
    ldre_pkg::norm_t    xd_reg [2];
    ldre_pkg::norm_t    pix [2];
    ldre_pkg::norm_t    pu_reg [2];

    // Distance
    logic [64:0]        du [2];
    logic [64:0]        du_abs [2];
    logic [31:0]        pos_next [2];
    logic [31:0]        pos_reg [2][D_POS];
    logic [31:0]        au_reg [2];
    logic               big_du_reg, big_sq_reg;
    logic [63:0]        sqp_reg [2];
    logic [64:0]        sq_sum;
    logic [63:0]        sq_s_reg [NSQ+1];
    logic [63:0]        sq_r_reg [NSQ+1];
    logic               sq_sat_reg [NSQ+1];
    logic [63:0]        sq_bit [NSQ+1];
    logic [63:0]        sq_trial [NSQ+1];
    logic               sq_ge [NSQ+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg       <= FOCAL_ONE;
            focal_y_reg       <= FOCAL_ONE;
            center_x_reg      <= '0;
            center_y_reg      <= '0;
            radial_k1_reg     <= '0;
            radial_k2_reg     <= '0;
            tangential_p1_reg <= '0;
            tangential_p2_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ldre_pkg::REG_FOCAL_X:       focal_x_reg       <= cfg_data[MAG_W-1:0];
                ldre_pkg::REG_FOCAL_Y:       focal_y_reg       <= cfg_data[MAG_W-1:0];
                ldre_pkg::REG_CENTER_X:      center_x_reg      <= cfg_data[MAG_W-1:0];
                ldre_pkg::REG_CENTER_Y:      center_y_reg      <= cfg_data[MAG_W-1:0];
                ldre_pkg::REG_RADIAL_K1:     radial_k1_reg     <= cfg_data;
                ldre_pkg::REG_RADIAL_K2:     radial_k2_reg     <= cfg_data;
                ldre_pkg::REG_TANGENTIAL_P1: tangential_p1_reg <= cfg_data;
                ldre_pkg::REG_TANGENTIAL_P2: tangential_p2_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // A focal length below one pixel is treated as exactly one pixel.
    assign foc_eff[0] = (focal_x_reg < FOCAL_ONE) ? FOCAL_ONE : focal_x_reg;
    assign foc_eff[1] = (focal_y_reg < FOCAL_ONE) ? FOCAL_ONE : focal_y_reg;
    assign ctr[0]     = center_x_reg;
    assign ctr[1]     = center_y_reg;
    assign k1_ext     = {{32{radial_k1_reg[31]}}, radial_k1_reg};
    assign k2_ext     = {{32{radial_k2_reg[31]}}, radial_k2_reg};
    assign p1_ext     = {{32{tangential_p1_reg[31]}}, tangential_p1_reg};
    assign p2_ext     = {{32{tangential_p2_reg[31]}}, tangential_p2_reg};
    assign tg_coef_a[0] = p1_ext;
    assign tg_coef_a[1] = p2_ext;
    assign tg_coef_c[0] = p2_ext;
    assign tg_coef_c[1] = p1_ext;

    assign pipe_ce    = !v_reg[T_LAST] || result_ready;
    assign item_ready = pipe_ce;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (pipe_ce)
        begin
            v_reg <= {v_reg[T_LAST-1:0], item_valid};
        end
    end

    assign in_est[0]  = item.estimate_u;
    assign in_est[1]  = item.estimate_v;

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            in_diff[l] = {1'b0, in_est[l]} - {1'b0, ctr[l]};
            dv_trial[l][0] = '0;
            dv_fit[l][0]   = 1'b0;
            // Dividend bits come from the top of a left-shifting magnitude;
            // once it is used up the zero fraction bits follow.
            for (int s = 1; s <= DIV_STEPS; s++)
            begin
                dv_trial[l][s] = {dv_rem_reg[l][s-1], dv_mag_reg[l][s-1][MAG_W-1]};
                dv_fit[l][s]   = dv_trial[l][s] >= {1'b0, foc_eff[l]};
            end
            q_ext[l] = 64'(dv_quo_reg[l][DIV_STEPS]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_ce)
        begin
            for (int l = 0; l < 2; l++)
            begin
                dv_rem_reg[l][0] <= '0;
                dv_quo_reg[l][0] <= '0;
                dv_neg_reg[l][0] <= in_diff[l][MAG_W];
                dv_mag_reg[l][0] <= in_diff[l][MAG_W] ? MAG_W'(~in_diff[l] + 1'b1)
                                                      : in_diff[l][MAG_W-1:0];
                for (int s = 1; s <= DIV_STEPS; s++)
                begin
                    dv_rem_reg[l][s] <= dv_fit[l][s]
                        ? MAG_W'(dv_trial[l][s] - {1'b0, foc_eff[l]})
                        : dv_trial[l][s][MAG_W-1:0];
                    dv_quo_reg[l][s] <= {dv_quo_reg[l][s-1][DIV_STEPS-2:0], dv_fit[l][s]};
                    dv_mag_reg[l][s] <= {dv_mag_reg[l][s-1][MAG_W-2:0], 1'b0};
                    dv_neg_reg[l][s] <= dv_neg_reg[l][s-1];
                end
                x_reg[l] <= dv_neg_reg[l][DIV_STEPS] ? (64'd0 - q_ext[l]) : q_ext[l];
                for (int i = 0; i <= T_PU; i++)
                begin
                    if (i == 0)
                    begin
                        obs_reg[l][i] <= (l == 0) ? item.observed_u : item.observed_v;
                    end
                    else
                    begin
                        obs_reg[l][i] <= obs_reg[l][i-1];
                    end
                end
            end
        end
    end

    ldre_mul #(.SHIFT(ldre_pkg::NORM_FRAC), .ROUND(1'b0)) u_mul_xx
        (.clk(clk), .ce(pipe_ce), .a(x_reg[0]), .b(x_reg[0]), .p(xx));
    ldre_mul #(.SHIFT(ldre_pkg::NORM_FRAC), .ROUND(1'b0)) u_mul_yy
        (.clk(clk), .ce(pipe_ce), .a(x_reg[1]), .b(x_reg[1]), .p(yy));
    ldre_mul #(.SHIFT(ldre_pkg::NORM_FRAC), .ROUND(1'b0)) u_mul_xy
        (.clk(clk), .ce(pipe_ce), .a(x_reg[0]), .b(x_reg[1]), .p(xy));
    ldre_mul #(.SHIFT(ldre_pkg::NORM_FRAC), .ROUND(1'b0)) u_mul_r4
        (.clk(clk), .ce(pipe_ce), .a(r2_reg), .b(r2_reg), .p(r4));
    ldre_mul #(.SHIFT(ldre_pkg::COEF_FRAC), .ROUND(1'b0)) u_mul_k1
        (.clk(clk), .ce(pipe_ce), .a(k1_ext), .b(r2_reg), .p(t1));
    ldre_mul #(.SHIFT(ldre_pkg::COEF_FRAC), .ROUND(1'b0)) u_mul_k2
        (.clk(clk), .ce(pipe_ce), .a(k2_ext), .b(r4), .p(t2));

    for (genvar l = 0; l < 2; l++)
    begin : g_lane
        ldre_mul #(.SHIFT(ldre_pkg::NORM_FRAC), .ROUND(1'b0)) u_mul_rad
            (.clk(clk), .ce(pipe_ce), .a(xdl_reg[l][D_X-1]), .b(radial_reg), .p(xr[l]));
        // The doubled cross term folds its factor of two into the shift.
        ldre_mul #(.SHIFT(ldre_pkg::COEF_FRAC - 1), .ROUND(1'b0)) u_mul_ta
            (.clk(clk), .ce(pipe_ce), .a(tg_coef_a[l]), .b(xy_s_reg), .p(ta[l]));
        ldre_mul #(.SHIFT(ldre_pkg::COEF_FRAC), .ROUND(1'b0)) u_mul_tc
            (.clk(clk), .ce(pipe_ce), .a(tg_coef_c[l]), .b(ts_reg[l]), .p(tc[l]));
        ldre_mul #(.SHIFT(ldre_pkg::NORM_FRAC), .ROUND(1'b1)) u_mul_pix
            (.clk(clk), .ce(pipe_ce), .a(xd_reg[l]), .b(64'(foc_eff[l])), .p(pix[l]));
    end

    always_ff @(posedge clk)
    begin
        if (pipe_ce)
        begin
            r2_reg     <= ldre_pkg::sat_add(xx, yy);
            sq2_reg[0] <= ldre_pkg::sat_add(xx, xx);
            sq2_reg[1] <= ldre_pkg::sat_add(yy, yy);
            xy_reg     <= xy;
            xy_s_reg   <= xy_reg;
            for (int i = 0; i < D_RA; i++)
            begin
                rad_a_reg[i] <= (i == 0) ? ldre_pkg::sat_add(ldre_pkg::NORM_ONE, t1)
                                         : rad_a_reg[(i == 0) ? 0 : i - 1];
            end
            radial_reg <= ldre_pkg::sat_add(rad_a_reg[D_RA-1], t2);
            for (int l = 0; l < 2; l++)
            begin
                ts_reg[l] <= ldre_pkg::sat_add(r2_reg, sq2_reg[l]);
                xdl_reg[l][0] <= x_reg[l];
                for (int i = 1; i < D_X; i++)
                begin
                    xdl_reg[l][i] <= xdl_reg[l][i-1];
                end
                ta_reg[l][0] <= ta[l];
                tc_reg[l][0] <= tc[l];
                for (int i = 1; i < D_T; i++)
                begin
                    ta_reg[l][i] <= ta_reg[l][i-1];
                    tc_reg[l][i] <= tc_reg[l][i-1];
                end
                xa_reg[l] <= ldre_pkg::sat_add(xr[l], ta_reg[l][D_T-1]);
                xc_reg[l] <= tc_reg[l][D_T-1];
                xd_reg[l] <= ldre_pkg::sat_add(xa_reg[l], xc_reg[l]);
                pu_reg[l] <= ldre_pkg::sat_add(pix[l], 64'(ctr[l]));
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            du[l]     = {37'd0, obs_reg[l][T_PU]} - {pu_reg[l][63], pu_reg[l]};
            du_abs[l] = du[l][64] ? (65'd0 - du[l]) : du[l];
            if ((&pu_reg[l][63:31]) || !(|pu_reg[l][63:31]))
            begin
                pos_next[l] = pu_reg[l][31:0];
            end
            else
            begin
                pos_next[l] = pu_reg[l][63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end
        end
        sq_sum = 65'(sqp_reg[0]) + 65'(sqp_reg[1]);
        sq_bit[0]   = '0;
        sq_trial[0] = '0;
        sq_ge[0]    = 1'b0;
        for (int k = 1; k <= NSQ; k++)
        begin
            sq_bit[k]   = 64'd1 << (2 * NSQ - 2 * k);
            sq_trial[k] = sq_r_reg[k-1] + sq_bit[k];
            sq_ge[k]    = sq_s_reg[k-1] >= sq_trial[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_ce)
        begin
            for (int l = 0; l < 2; l++)
            begin
                au_reg[l]     <= du_abs[l][31:0];
                sqp_reg[l]    <= au_reg[l] * au_reg[l];
                pos_reg[l][0] <= pos_next[l];
                for (int i = 1; i < D_POS; i++)
                begin
                    pos_reg[l][i] <= pos_reg[l][i-1];
                end
            end
            big_du_reg    <= (|du_abs[0][64:32]) || (|du_abs[1][64:32]);
            big_sq_reg    <= big_du_reg;
            sq_s_reg[0]   <= sq_sum[63:0];
            sq_r_reg[0]   <= '0;
            sq_sat_reg[0] <= big_sq_reg || sq_sum[64];
            for (int k = 1; k <= NSQ; k++)
            begin
                sq_s_reg[k]   <= sq_ge[k] ? (sq_s_reg[k-1] - sq_trial[k]) : sq_s_reg[k-1];
                sq_r_reg[k]   <= sq_ge[k] ? ((sq_r_reg[k-1] >> 1) + sq_bit[k])
                                          : (sq_r_reg[k-1] >> 1);
                sq_sat_reg[k] <= sq_sat_reg[k-1];
            end
        end
    end

    assign result_valid          = v_reg[T_LAST];
    assign result.distorted_u    = pos_reg[0][D_POS-1];
    assign result.distorted_v    = pos_reg[1][D_POS-1];
    assign result.error_distance = sq_sat_reg[NSQ] ? 32'hFFFF_FFFF : sq_r_reg[NSQ][31:0];

    `LDRE_ASSERT_NEXT(a_stall_holds_valids, clk, rst_n, !pipe_ce, $stable(v_reg))
    `LDRE_ASSERT_IMPL(a_div_rem_below_focal, clk, rst_n, v_reg[DIV_STEPS], dv_rem_reg[0][DIV_STEPS] < foc_eff[0])
    `LDRE_ASSERT_IMPL(a_sqrt_fits_32, clk, rst_n, v_reg[T_LAST], sq_r_reg[NSQ][63:32] == 32'd0)

endmodule

// ----- rtl/core/ldre_mul.sv -----
module ldre_mul #(
    parameter int SHIFT = 30,
    parameter bit ROUND = 1'b0
) (
    input  logic            clk,
    input  logic            ce,
    input  ldre_pkg::norm_t a,
    input  ldre_pkg::norm_t b,
    output ldre_pkg::norm_t p
);

    localparam logic [127:0] RND_ADD = ROUND ? (128'd1 << (SHIFT - 1)) : 128'd0;

    logic [63:0]     a_abs;
    logic [63:0]     b_abs;
    logic [2:0]      neg_reg;
    logic [62:0]     ua_reg;
    logic [62:0]     ub_reg;
    logic [63:0]     p00_reg;
    logic [62:0]     p01_reg;
    logic [62:0]     p10_reg;
    logic [61:0]     p11_reg;
    logic [127:0]    mag_reg;
    logic [127:0]    sum_c;
    logic [127:0]    shifted;
    logic            in_range;
    ldre_pkg::norm_t p_reg;

    assign a_abs = a[63] ? (64'd0 - a) : a;
    assign b_abs = b[63] ? (64'd0 - b) : b;

    // Two's complement of the magnitude and the rounding constant in one add.
    assign sum_c    = (mag_reg ^ {128{neg_reg[2]}}) + 128'(neg_reg[2]) + RND_ADD;
    assign shifted  = 128'($signed(sum_c) >>> SHIFT);
    assign in_range = (&shifted[127:62]) || !(|shifted[127:62]);

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            neg_reg <= {neg_reg[1:0], a[63] ^ b[63]};
            ua_reg  <= a_abs[62:0];
            ub_reg  <= b_abs[62:0];
            p00_reg <= ua_reg[31:0] * ub_reg[31:0];
            p01_reg <= ua_reg[31:0] * ub_reg[62:32];
            p10_reg <= ua_reg[62:32] * ub_reg[31:0];
            p11_reg <= ua_reg[62:32] * ub_reg[62:32];
            mag_reg <= 128'(p00_reg) + (128'(p01_reg) << 32) + (128'(p10_reg) << 32)
                       + (128'(p11_reg) << 64);
            p_reg   <= in_range ? shifted[63:0]
                                : (shifted[127] ? ldre_pkg::SAT_LO : ldre_pkg::SAT_HI);
        end
    end

    assign p = p_reg;

endmodule
